>>> design/rrb_pkg.sv
// shared constants, codes and types for the receive ring buffer
`default_nettype none
package rrb_pkg;

  // buffer geometry
  localparam int DEPTH  = 1024;
  localparam int AW     = $clog2(DEPTH);
  localparam int FW     = $clog2(DEPTH + 1);
  localparam int LVL_W  = 11;
  localparam int CMP_W  = (FW > LVL_W) ? FW : LVL_W;

  localparam logic [FW-1:0] DEPTH_F   = FW'(DEPTH);
  localparam logic [AW-1:0] LAST_POS  = AW'(DEPTH - 1);

  // register reset values and masks
  localparam logic [LVL_W-1:0] STOP_RESET   = LVL_W'(128);
  localparam logic [LVL_W-1:0] RESUME_RESET = LVL_W'(256);
  localparam logic [7:0]       LOW7_MASK    = 8'h7F;

  // operation codes
  localparam logic [1:0] MODE_RECV  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_UNGET = 2'd2;
  localparam logic [1:0] MODE_FLUSH = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVERRUN = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_STOP   = 2'd0;
  localparam logic [1:0] REG_RESUME = 2'd1;
  localparam logic [1:0] REG_STRIP  = 2'd2;

  // result word fields known at accept time, byte comes from the ram later
  typedef struct packed {
    logic       rd_ok;
    logic       rts_on;
    logic       not_empty;
    logic [1:0] status;
  } res_ctl_t;

  // ring position step with wrap
  function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] p);
    return (p == LAST_POS) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] pos_dec(input logic [AW-1:0] p);
    return (p == '0) ? LAST_POS : p - AW'(1);
  endfunction

endpackage
`default_nettype wire

>>> design/rrb_if.sv
// channel interfaces: input operation, result word and register write
`default_nettype none
interface rrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] byte_in;
  modport source (output valid, mode, byte_in, input ready);
  modport sink   (input valid, mode, byte_in, output ready);
endinterface

interface rrb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       byte_valid;
  logic       rts_on;
  logic       not_empty;
  logic [1:0] status;
  modport source (output valid, byte_out, byte_valid, rts_on, not_empty, status,
                  input ready);
  modport sink   (input valid, byte_out, byte_valid, rts_on, not_empty, status,
                  output ready);
endinterface

interface rrb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/rrb_ram.sv
// single-port synchronous ram, registered read data
`default_nettype none
module rrb_ram #(
  parameter int W = 8,
  parameter int N = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic                 we,
  input  wire logic [$clog2(N)-1:0] addr,
  input  wire logic [W-1:0]         wdata,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [N];

  // write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

>>> design/rx_ring_buffer_rts_watermark.sv
// Receive ring buffer with hysteresis RTS flow control.
// Channels: item (mode, byte_in) takes one operation per word: receive a
// byte, read the oldest byte, push a byte back to the front, or flush.
// result returns one word per operation: byte_out, byte_valid, rts_on,
// not_empty and status (ok, overrun, read of empty). cfg writes
// stop_level, resume_level and strip_high_bit; it is always ready.
// Timing: the ram read and the s1 register load at the edge that accepts an
// operation; the output register loads from s1 once it is empty or its word
// is taken.
// Throughput: one operation per cycle while result is taken; pointer and
// free-space state update at accept, so back-to-back operations see each
// other at once, and the single ram port is used at most once per operation.
// Receiver stall: the output register holds its word and the stage behind
// it holds its word and the ram read data; item.ready drops once both are
// full and returns as soon as result is taken.
// Reset: pointers to zero, buffer empty, RTS raised, registers to their
// reset values. Ram contents are left as they are, since only written
// entries are ever read.
`default_nettype none
module rx_ring_buffer_rts_watermark
  import rrb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  rrb_in_if.sink     item,
  rrb_out_if.source  result,
  rrb_cfg_if.sink    cfg
);

  // configuration registers
  logic [LVL_W-1:0] stop_level;
  logic [LVL_W-1:0] resume_level;
  logic             strip_high_bit;

  // ring state
  logic [AW-1:0] write_pos, write_pos_next;
  logic [AW-1:0] read_pos, read_pos_next;
  logic [FW-1:0] free_space, free_space_next;
  logic          throttled, throttled_next;

  // pipeline: s1 waits for ram data, then the output register
  logic     s1_valid;
  res_ctl_t s1_ctl;
  res_ctl_t ctl_next;
  logic     s1_adv;
  logic     accept;

  // ram access for this operation
  logic          ram_en;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic [7:0]    rd_byte;

  assign cfg.ready  = 1'b1;
  assign s1_adv     = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;
  assign accept     = item.valid && item.ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_level     <= STOP_RESET;
      resume_level   <= RESUME_RESET;
      strip_high_bit <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_STOP:   stop_level     <= cfg.data;
        REG_RESUME: resume_level   <= cfg.data;
        REG_STRIP:  strip_high_bit <= cfg.data[0];
        default:    ;
      endcase
    end
  end

  // operation decode and next state
  always_comb begin
    write_pos_next  = write_pos;
    read_pos_next   = read_pos;
    free_space_next = free_space;
    throttled_next  = throttled;
    ram_we          = 1'b0;
    ram_addr        = read_pos;
    ctl_next.rd_ok  = 1'b0;
    ctl_next.status = ST_OK;
    unique case (item.mode)
      MODE_RECV: begin
        ram_addr = write_pos;
        if (free_space == '0) begin
          ctl_next.status = ST_OVERRUN;
        end else begin
          ram_we          = 1'b1;
          write_pos_next  = pos_inc(write_pos);
          free_space_next = free_space - FW'(1);
          if (CMP_W'(free_space_next) < CMP_W'(stop_level)) begin
            throttled_next = 1'b1;
          end
        end
      end
      MODE_READ: begin
        if (free_space == DEPTH_F) begin
          ctl_next.status = ST_EMPTY;
        end else begin
          ctl_next.rd_ok  = 1'b1;
          read_pos_next   = pos_inc(read_pos);
          free_space_next = free_space + FW'(1);
          if (throttled && CMP_W'(free_space_next) >= CMP_W'(resume_level)) begin
            throttled_next = 1'b0;
          end
        end
      end
      MODE_UNGET: begin
        ram_addr = pos_dec(read_pos);
        if (free_space == '0) begin
          ctl_next.status = ST_OVERRUN;
        end else begin
          ram_we          = 1'b1;
          read_pos_next   = pos_dec(read_pos);
          free_space_next = free_space - FW'(1);
        end
      end
      MODE_FLUSH: begin
        write_pos_next  = '0;
        read_pos_next   = '0;
        free_space_next = DEPTH_F;
        throttled_next  = 1'b0;
      end
      default: ;
    endcase
    ctl_next.rts_on    = !throttled_next;
    ctl_next.not_empty = free_space_next != DEPTH_F;
    ram_en             = accept && (ram_we || ctl_next.rd_ok);
  end

  // ring state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos  <= '0;
      read_pos   <= '0;
      free_space <= DEPTH_F;
      throttled  <= 1'b0;
    end else if (accept) begin
      write_pos  <= write_pos_next;
      read_pos   <= read_pos_next;
      free_space <= free_space_next;
      throttled  <= throttled_next;
    end
  end

  rrb_ram #(
    .W (8),
    .N (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (item.byte_in),
    .rdata (ram_rdata)
  );

  // stage waiting for ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl <= ctl_next;
    end
  end

  // byte selection with optional bit 7 strip
  always_comb begin
    rd_byte = '0;
    if (s1_ctl.rd_ok) begin
      rd_byte = strip_high_bit ? (ram_rdata & LOW7_MASK) : ram_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (!result.valid || result.ready) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.byte_out   <= rd_byte;
      result.byte_valid <= s1_ctl.rd_ok;
      result.rts_on     <= s1_ctl.rts_on;
      result.not_empty  <= s1_ctl.not_empty;
      result.status     <= s1_ctl.status;
    end
  end

  // free space never exceeds the buffer size
  a_free_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(free_space) <= CMP_W'(DEPTH_F))
    else $error("free space above buffer depth");

  // an empty or full ring has equal positions
  a_pos_match: assert property (@(posedge clk) disable iff (rst)
    (free_space == DEPTH_F || free_space == '0) |-> write_pos == read_pos)
    else $error("ring positions disagree with free space");

  // ram data stays put while its word waits in s1
  a_rdata_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> $stable(ram_rdata))
    else $error("ram read data changed under a stalled word");

  // flush empties the ring and raises rts
  a_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && item.mode == MODE_FLUSH) |=> (free_space == DEPTH_F && !throttled))
    else $error("flush did not empty the ring");

  // a returned byte always carries ok status
  a_rd_status: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ctl.rd_ok) |-> s1_ctl.status == ST_OK)
    else $error("read byte with error status");

endmodule
`default_nettype wire

>>> bench/tb_rx_ring_buffer_rts_watermark.sv
// testbench for the receive ring buffer with rts watermark flow control
`timescale 1ns / 100ps
module tb_rx_ring_buffer_rts_watermark
  import rrb_pkg::*;
();

  // index that maps to no register
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 6;

  // one result word as the block reports it
  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       rts_on;
    logic       not_empty;
    logic [1:0] status;
  } rx_word_t;

  logic clk = 1'b0;
  logic rst;

  rrb_in_if  item_ch ();
  rrb_out_if res_ch ();
  rrb_cfg_if cfg_ch ();

  rx_ring_buffer_rts_watermark dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #10 clk = ~clk;

  // shadow copy of buffer state and registers
  logic [7:0]       shadow_mem [DEPTH];
  logic [AW-1:0]    shadow_wr;
  logic [AW-1:0]    shadow_rd;
  int unsigned      shadow_free;
  bit               shadow_held;
  logic [LVL_W-1:0] stop_lvl;
  logic [LVL_W-1:0] resume_lvl;
  bit               strip_on;

  rx_word_t pending_words [$];
  int       fail_count = 0;
  bit       gaps_on = 1'b1;
  int       hold_left = 0;
  int       idle_cycles = 0;

  function automatic logic [AW-1:0] ring_next(logic [AW-1:0] p);
    return AW'((int'(p) + 1) % DEPTH);
  endfunction

  // expected word for one operation, advancing the shadow state
  function automatic rx_word_t apply_op(logic [1:0] m, logic [7:0] b);
    rx_word_t w;
    w = '0;
    w.status = ST_OK;
    case (m)
      MODE_RECV: begin
        if (shadow_free == 0) begin
          w.status = ST_OVERRUN;
        end else begin
          shadow_mem[shadow_wr] = b;
          shadow_wr = ring_next(shadow_wr);
          shadow_free--;
          if (shadow_free < stop_lvl) shadow_held = 1'b1;
        end
      end
      MODE_READ: begin
        if (shadow_free >= DEPTH) begin
          w.status = ST_EMPTY;
        end else begin
          w.byte_out = strip_on ? (shadow_mem[shadow_rd] & LOW7_MASK) : shadow_mem[shadow_rd];
          w.byte_valid = 1'b1;
          shadow_rd = ring_next(shadow_rd);
          shadow_free++;
          if (shadow_held && shadow_free >= resume_lvl) shadow_held = 1'b0;
        end
      end
      MODE_UNGET: begin
        if (shadow_free == 0) begin
          w.status = ST_OVERRUN;
        end else begin
          // step back in front of the oldest byte, wrapping below zero
          shadow_rd = AW'((int'(shadow_rd) + DEPTH - 1) % DEPTH);
          shadow_mem[shadow_rd] = b;
          shadow_free--;
        end
      end
      default: begin
        shadow_wr = '0;
        shadow_rd = '0;
        shadow_free = DEPTH;
        shadow_held = 1'b0;
      end
    endcase
    w.rts_on = !shadow_held;
    w.not_empty = (shadow_free < DEPTH);
    return w;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // send one operation word and record its expected result
  task automatic send_item(logic [1:0] m, logic [7:0] b);
    if (gaps_on && $urandom_range(0, 11) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.mode <= m;
    item_ch.byte_in <= b;
    do @(posedge clk); while (!item_ch.ready);
    pending_words.push_back(apply_op(m, b));
  endtask

  // hold off the sender until every result is back
  task automatic wait_results;
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  // quiet the block so registers may be written
  task automatic settle_block;
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_STOP:   stop_lvl = val;
      REG_RESUME: resume_lvl = val;
      REG_STRIP:  strip_on = val[0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // random operation, leaning toward filling or draining
  task automatic send_random(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) send_item(MODE_FLUSH, 8'($urandom_range(0, 255)));
    else if (r < 12) send_item(MODE_UNGET, 8'($urandom_range(0, 255)));
    else if (r < (filling ? 72 : 37)) send_item(MODE_RECV, 8'($urandom_range(0, 255)));
    else send_item(MODE_READ, 8'($urandom_range(0, 255)));
  endtask

  // edges of each operation from the reset state
  task automatic test_directed;
    send_item(MODE_READ, 8'hFF);
    send_item(MODE_FLUSH, 8'hA5);
    send_item(MODE_UNGET, 8'h81);
    send_item(MODE_RECV, 8'h00);
    send_item(MODE_RECV, 8'hFF);
    repeat (4) send_item(MODE_READ, 8'h00);
    send_item(MODE_RECV, 8'h7F);
    send_item(MODE_RECV, 8'h80);
    send_item(MODE_UNGET, 8'h55);
    send_item(MODE_UNGET, 8'hAA);
    send_item(MODE_READ, 8'h3C);
    send_item(MODE_READ, 8'hC3);
    send_item(MODE_FLUSH, 8'h00);
    send_item(MODE_READ, 8'hFF);
    send_item(MODE_RECV, 8'hC3);
    send_item(MODE_READ, 8'h00);
  endtask

  // bit 7 strip, register masking and the unused index
  task automatic test_registers;
    settle_block();
    write_reg(REG_NONE, 11'h7FF);
    write_reg(REG_STRIP, 11'h001);
    send_item(MODE_RECV, 8'hFF);
    send_item(MODE_RECV, 8'h80);
    send_item(MODE_UNGET, 8'hD5);
    repeat (3) send_item(MODE_READ, 8'h00);
    settle_block();
    write_reg(REG_STRIP, 11'h7FE);
    send_item(MODE_RECV, 8'hFF);
    send_item(MODE_READ, 8'h00);
  endtask

  // hysteresis under several stop and resume settings
  task automatic test_levels;
    logic [10:0] stop_set [7];
    logic [10:0] resume_set [7];
    stop_set   = '{11'd1024, 11'd0, 11'd2047, 11'd1, 11'd1016, 11'd1022, 11'd0};
    resume_set = '{11'd1024, 11'd1024, 11'd2047, 11'd1, 11'd1020, 11'd1010, 11'd0};
    stop_set[6] = 11'($urandom_range(1000, 1024));
    resume_set[6] = 11'($urandom_range(990, 2047));
    for (int k = 0; k < 7; k++) begin
      settle_block();
      write_reg(REG_NONE, 11'($urandom_range(0, 2047)));
      write_reg(REG_STOP, stop_set[k]);
      write_reg(REG_RESUME, resume_set[k]);
      write_reg(REG_STRIP, 11'($urandom_range(0, 2047)));
      for (int n = 0; n < 60; n++) begin
        if (n == 30) wait_results();
        send_random(n < 30);
      end
    end
  endtask

  // fill to full at default levels, overrun, then drain past resume
  task automatic test_full_buffer;
    int r;
    settle_block();
    write_reg(REG_STOP, STOP_RESET);
    write_reg(REG_RESUME, RESUME_RESET);
    write_reg(REG_STRIP, 11'h000);
    while (shadow_free != 0) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_item(MODE_READ, 8'($urandom_range(0, 255)));
      else if (r < 8) send_item(MODE_UNGET, 8'($urandom_range(0, 255)));
      else send_item(MODE_RECV, 8'($urandom_range(0, 255)));
    end
    repeat (3) send_item(MODE_RECV, 8'($urandom_range(0, 255)));
    repeat (3) send_item(MODE_UNGET, 8'($urandom_range(0, 255)));
    // last stretch runs without idling on either side
    gaps_on = 1'b0;
    while (shadow_free < 300) begin
      r = $urandom_range(0, 99);
      if (r < 10) send_item(MODE_UNGET, 8'($urandom_range(0, 255)));
      else if (r < 15) send_item(MODE_RECV, 8'($urandom_range(0, 255)));
      else send_item(MODE_READ, 8'($urandom_range(0, 255)));
    end
    send_item(MODE_FLUSH, 8'($urandom_range(0, 255)));
    send_item(MODE_READ, 8'($urandom_range(0, 255)));
  endtask

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= (hold_left == 1);
    end else if (gaps_on && $urandom_range(0, 13) == 0) begin
      hold_left <= $urandom_range(1, 17);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // compare each result word with the oldest expected one
  always @(posedge clk) begin
    rx_word_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result word byte_out %0h status %0h", $time,
                 res_ch.byte_out, res_ch.status);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("byte_out", want.byte_out, res_ch.byte_out);
        check_field("byte_valid", 8'(want.byte_valid), 8'(res_ch.byte_valid));
        check_field("rts_on", 8'(want.rts_on), 8'(res_ch.rts_on));
        check_field("not_empty", 8'(want.not_empty), 8'(res_ch.not_empty));
        check_field("status", 8'(want.status), 8'(res_ch.status));
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_rx_ring_buffer_rts_watermark failed");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.mode <= MODE_RECV;
    item_ch.byte_in <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_STOP;
    cfg_ch.data <= '0;
    shadow_wr = '0;
    shadow_rd = '0;
    shadow_free = DEPTH;
    shadow_held = 1'b0;
    stop_lvl = STOP_RESET;
    resume_lvl = RESUME_RESET;
    strip_on = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_registers();
    test_levels();
    test_full_buffer();
    settle_block();
    if (fail_count == 0) begin
      $display("tb_rx_ring_buffer_rts_watermark passed");
    end else begin
      $display("tb_rx_ring_buffer_rts_watermark failed");
    end
    $finish;
  end

endmodule
